// ----- src/swmf_pkg.sv -----
// ----------------------------------------------------------------------------
// swmf_pkg: shared types and constants of the mission supervisor
// Item formats, mission state codes, request codes and register indexes.
// ----------------------------------------------------------------------------
package swmf_pkg;

  localparam int LIMIT_W  = 24;
  localparam int N_TIMERS = 7;
  localparam int N_LIMITS = 7;
  localparam int CFG_IDX_W = 3;

  // Mission state codes.
  localparam logic [3:0] ST_WAIT_START  = 4'd0;
  localparam logic [3:0] ST_WAIT_ODOM   = 4'd1;
  localparam logic [3:0] ST_WAIT_LASER  = 4'd2;
  localparam logic [3:0] ST_WAIT_DEPTH  = 4'd3;
  localparam logic [3:0] ST_WAIT_PEOPLE = 4'd4;
  localparam logic [3:0] ST_RUNNING     = 4'd5;
  localparam logic [3:0] ST_LOST        = 4'd6;
  localparam logic [3:0] ST_FINISHED    = 4'd7;
  localparam logic [3:0] ST_ABORTED     = 4'd8;

  // Request codes.
  localparam logic [3:0] REQ_TICK       = 4'd0;
  localparam logic [3:0] REQ_CYCLE      = 4'd1;
  localparam logic [3:0] REQ_START      = 4'd2;
  localparam logic [3:0] REQ_STOP       = 4'd3;
  localparam logic [3:0] REQ_SEL_TARGET = 4'd4;
  localparam logic [3:0] REQ_SEL_MODE   = 4'd5;
  localparam logic [3:0] REQ_ODOM       = 4'd6;
  localparam logic [3:0] REQ_LASER      = 4'd7;
  localparam logic [3:0] REQ_DEPTH      = 4'd8;
  localparam logic [3:0] REQ_PEOPLE     = 4'd9;

  // Timer indexes; limit registers share this order.
  localparam int T_ODOM   = 0;
  localparam int T_LASER  = 1;
  localparam int T_DEPTH  = 2;
  localparam int T_PEOPLE = 3;
  localparam int T_FINISH = 4;
  localparam int T_LOST   = 5;
  localparam int T_STALL  = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ODOM_LIMIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LASER_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PEOPLE_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FINISH_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOST_LIMIT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIMIT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_ENABLED = 3'd7;

  localparam logic [7:0] ABORT_MODE  = 8'd100;
  localparam logic [7:0] GOAL_EPS_SQ = 8'd100;
  // Largest goal offset, per axis, that can still lie within the goal radius.
  localparam logic [24:0] GOAL_AXIS_MAX = 25'd9;
  localparam logic [24:0] GOAL_AXIS_MIN = 25'h1FFFFF7;

  typedef struct packed {
    logic [3:0]         req_type;
    logic [15:0]        person_id;
    logic [7:0]         mode_code;
    logic               msg_valid;
    logic               target_found;
    logic               finishing;
    logic signed [23:0] goal_x;
    logic signed [23:0] goal_y;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  mission_state;
    logic        cmd_rejected;
    logic        stop_robot;
    logic [15:0] current_target;
    logic [7:0]  current_mode;
  } out_item_t;

  typedef struct packed {
    logic [N_LIMITS-1:0][LIMIT_W-1:0] limit;
    logic                             depth_enabled;
  } cfg_t;

  // Supervisor state apart from the elapsed timers.
  typedef struct packed {
    logic [3:0]         mission;
    logic [15:0]        target;
    logic [7:0]         mode;
    logic               finishing;
    logic signed [23:0] last_goal_x;
    logic signed [23:0] last_goal_y;
  } core_t;

endpackage

// ----- src/swmf_step.sv -----
// ----------------------------------------------------------------------------
// swmf_step: next-state logic of the mission supervisor
// Works out the new state, timers and result for one item in a single pass.
// ----------------------------------------------------------------------------
module swmf_step #(
  parameter int TIMER_BITS = 24
) (
  input  swmf_pkg::cfg_t                                   cfg,
  input  swmf_pkg::in_item_t                               item,
  input  swmf_pkg::core_t                                  cur,
  input  logic [swmf_pkg::N_TIMERS-1:0][TIMER_BITS-1:0]    cur_elapsed,
  output swmf_pkg::core_t                                  nxt,
  output logic [swmf_pkg::N_TIMERS-1:0][TIMER_BITS-1:0]    nxt_elapsed,
  output swmf_pkg::out_item_t                              result
);

  localparam int CMP_W = (TIMER_BITS > swmf_pkg::LIMIT_W) ? TIMER_BITS : swmf_pkg::LIMIT_W;

  logic [swmf_pkg::N_TIMERS-1:0] expired;
  logic [3:0]                    ns;
  logic                          idle;
  logic                          err;
  logic                          stop;
  logic                          fin_rise;
  logic [24:0]                   dx;
  logic [24:0]                   dy;
  logic                          near_x;
  logic                          near_y;
  logic [3:0]                    mag_x;
  logic [3:0]                    mag_y;
  logic [7:0]                    dist_sq;
  logic                          goal_near;

  always_comb begin
    for (int i = 0; i < swmf_pkg::N_TIMERS; i++) begin
      expired[i] = CMP_W'(cur_elapsed[i]) > CMP_W'(cfg.limit[i]);
    end
  end

  // The goal is unchanged when it moved by less than the goal radius; that is only
  // possible when both offsets are small, so the magnitudes stay four bits wide.
  always_comb begin
    dx      = {cur.last_goal_x[23], cur.last_goal_x} - {item.goal_x[23], item.goal_x};
    dy      = {cur.last_goal_y[23], cur.last_goal_y} - {item.goal_y[23], item.goal_y};
    near_x  = dx[24] ? (dx >= swmf_pkg::GOAL_AXIS_MIN) : (dx <= swmf_pkg::GOAL_AXIS_MAX);
    near_y  = dy[24] ? (dy >= swmf_pkg::GOAL_AXIS_MIN) : (dy <= swmf_pkg::GOAL_AXIS_MAX);
    mag_x   = dx[24] ? 4'(-dx) : dx[3:0];
    mag_y   = dy[24] ? 4'(-dy) : dy[3:0];
    dist_sq = ({4'd0, mag_x} * {4'd0, mag_x}) + ({4'd0, mag_y} * {4'd0, mag_y});
    goal_near = near_x && near_y && (dist_sq < swmf_pkg::GOAL_EPS_SQ);
  end

  always_comb begin
    nxt         = cur;
    nxt_elapsed = cur_elapsed;
    ns          = cur.mission;
    err         = 1'b0;
    stop        = 1'b0;
    fin_rise    = !cur.finishing && item.finishing;
    idle        = (cur.mission == swmf_pkg::ST_WAIT_START) ||
                  (cur.mission == swmf_pkg::ST_FINISHED) ||
                  (cur.mission == swmf_pkg::ST_ABORTED);

    case (item.req_type)
      swmf_pkg::REQ_TICK: begin
        for (int i = 0; i < swmf_pkg::N_TIMERS; i++) begin
          if (cur_elapsed[i] != {TIMER_BITS{1'b1}}) begin
            nxt_elapsed[i] = cur_elapsed[i] + TIMER_BITS'(1);
          end
        end
      end
      swmf_pkg::REQ_CYCLE: begin
        if (!idle) begin
          if (cur.mission != swmf_pkg::ST_WAIT_ODOM && expired[swmf_pkg::T_ODOM]) begin
            ns = swmf_pkg::ST_WAIT_ODOM;
          end else if (cur.mission > swmf_pkg::ST_WAIT_LASER &&
                       expired[swmf_pkg::T_LASER]) begin
            ns = swmf_pkg::ST_WAIT_LASER;
          end else if (cfg.depth_enabled && cur.mission > swmf_pkg::ST_WAIT_DEPTH &&
                       expired[swmf_pkg::T_DEPTH]) begin
            ns = swmf_pkg::ST_WAIT_DEPTH;
          end else if (cur.mission > swmf_pkg::ST_WAIT_PEOPLE &&
                       expired[swmf_pkg::T_PEOPLE]) begin
            ns = swmf_pkg::ST_WAIT_PEOPLE;
          end else if (cur.mission == swmf_pkg::ST_RUNNING ||
                       cur.mission == swmf_pkg::ST_LOST) begin
            if (cur.mission == swmf_pkg::ST_LOST && expired[swmf_pkg::T_LOST]) begin
              ns = swmf_pkg::ST_ABORTED;
            end else begin
              if (fin_rise) begin
                nxt_elapsed[swmf_pkg::T_FINISH] = '0;
              end
              nxt.finishing = item.finishing;
              if (cur.mission == swmf_pkg::ST_RUNNING && item.finishing && !fin_rise &&
                  expired[swmf_pkg::T_FINISH]) begin
                nxt.finishing = 1'b0;
                ns = swmf_pkg::ST_FINISHED;
              end else if (cur.mission == swmf_pkg::ST_RUNNING && goal_near &&
                           expired[swmf_pkg::T_STALL]) begin
                ns = swmf_pkg::ST_ABORTED;
              end else begin
                nxt.last_goal_x = item.goal_x;
                nxt.last_goal_y = item.goal_y;
                nxt_elapsed[swmf_pkg::T_STALL] = '0;
              end
            end
          end
        end
      end
      swmf_pkg::REQ_START: begin
        if (!idle) begin
          err = 1'b1;
        end else begin
          nxt.target = item.person_id;
          ns = swmf_pkg::ST_WAIT_ODOM;
        end
      end
      swmf_pkg::REQ_STOP: begin
        if (idle) begin
          err = 1'b1;
        end else begin
          ns = swmf_pkg::ST_FINISHED;
        end
      end
      swmf_pkg::REQ_SEL_TARGET: begin
        if (idle) begin
          err = 1'b1;
        end else begin
          nxt.target = item.person_id;
        end
      end
      swmf_pkg::REQ_SEL_MODE: begin
        if (idle) begin
          err = 1'b1;
        end else if (item.mode_code == swmf_pkg::ABORT_MODE) begin
          ns = swmf_pkg::ST_ABORTED;
        end else begin
          nxt.mode = item.mode_code;
        end
      end
      swmf_pkg::REQ_ODOM: begin
        if (!idle && item.msg_valid) begin
          nxt_elapsed[swmf_pkg::T_ODOM] = '0;
          if (cur.mission == swmf_pkg::ST_WAIT_ODOM) begin
            ns = swmf_pkg::ST_WAIT_LASER;
          end
        end
      end
      swmf_pkg::REQ_LASER: begin
        if (!idle && item.msg_valid) begin
          nxt_elapsed[swmf_pkg::T_LASER] = '0;
          if (cur.mission == swmf_pkg::ST_WAIT_LASER) begin
            ns = cfg.depth_enabled ? swmf_pkg::ST_WAIT_DEPTH : swmf_pkg::ST_WAIT_PEOPLE;
          end
        end
      end
      swmf_pkg::REQ_DEPTH: begin
        if (cfg.depth_enabled && !idle && item.msg_valid) begin
          nxt_elapsed[swmf_pkg::T_DEPTH] = '0;
          if (cur.mission == swmf_pkg::ST_WAIT_DEPTH) begin
            ns = swmf_pkg::ST_WAIT_PEOPLE;
          end
        end
      end
      swmf_pkg::REQ_PEOPLE: begin
        if (!idle && item.msg_valid) begin
          nxt_elapsed[swmf_pkg::T_PEOPLE] = '0;
          if (cur.mission == swmf_pkg::ST_RUNNING && !item.target_found) begin
            ns = swmf_pkg::ST_LOST;
          end else if (cur.mission == swmf_pkg::ST_LOST && item.target_found) begin
            ns = swmf_pkg::ST_RUNNING;
          end else if (cur.mission == swmf_pkg::ST_WAIT_PEOPLE) begin
            ns = item.target_found ? swmf_pkg::ST_RUNNING : swmf_pkg::ST_LOST;
          end
        end
      end
      default: begin
      end
    endcase

    // At most one state change happens per item; its side effects are applied here.
    if (ns != cur.mission) begin
      stop = (cur.mission == swmf_pkg::ST_RUNNING && ns != swmf_pkg::ST_LOST) ||
             (cur.mission == swmf_pkg::ST_LOST && ns != swmf_pkg::ST_RUNNING);
      if (ns == swmf_pkg::ST_LOST) begin
        nxt_elapsed[swmf_pkg::T_LOST] = '0;
      end
      if (ns == swmf_pkg::ST_RUNNING) begin
        nxt_elapsed[swmf_pkg::T_STALL] = '0;
      end
    end
    nxt.mission = ns;

    result.mission_state  = ns;
    result.cmd_rejected   = err;
    result.stop_robot     = stop;
    result.current_target = nxt.target;
    result.current_mode   = nxt.mode;
  end

endmodule

// ----- src/sensor_watchdog_mission_fsm_core.sv -----
// ----------------------------------------------------------------------------
// sensor_watchdog_mission_fsm_core: mission supervisor with sensor watchdogs
// Nine-state supervisor with seven saturating elapsed timers.
// ----------------------------------------------------------------------------
// How the block is used:
// Items arrive on the in_ channel (valid/ready) as ticks, control cycles,
// commands or sensor arrivals. Every accepted item yields exactly one result
// item on the out_ channel (valid/ready), carrying the mission state after the
// item, the rejection flag, the stop pulse and the stored target and mode.
// The result is registered, appearing in the cycle after its item is accepted.
// The state update is one registered pass, so one item is taken each cycle for
// as long as the receiver keeps up; the output register sets that figure.
// When the receiver stalls, the result is held in the output register and
// in_ready drops until it is taken; an item is accepted in the same cycle as
// the waiting result leaves.
// The cfg_ port writes one limit or the depth enable per cycle, with no wait.
// The user writes it only while no item is in flight; the block won't check.
// Reset (synchronous, active low) puts the supervisor in waiting for start,
// clears all timers, the target, the mode and the latched goal, loads the
// default limits and empties the output register.
// ----------------------------------------------------------------------------
module sensor_watchdog_mission_fsm_core #(
  parameter int TIMER_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  swmf_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output swmf_pkg::out_item_t                    out_data,
  input  logic                                   cfg_we,
  input  logic [swmf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [swmf_pkg::LIMIT_W-1:0]           cfg_data
);

  // Configuration registers.
  swmf_pkg::cfg_t cfg_r;

  // Supervisor state: mission, target, mode, finishing flag, latched goal.
  swmf_pkg::core_t core_r;
  swmf_pkg::core_t core_nxt;

  // Elapsed timers, in the order odometry, laser, depth, people, finish,
  // lost and stall.
  logic [swmf_pkg::N_TIMERS-1:0][TIMER_BITS-1:0] elapsed_r;
  logic [swmf_pkg::N_TIMERS-1:0][TIMER_BITS-1:0] elapsed_nxt;

  // Result register, which parts the two channels.
  logic                out_valid_r;
  swmf_pkg::out_item_t out_data_r;
  swmf_pkg::out_item_t step_result;

  logic in_fire;

  // A new item is taken when the result register is empty or is emptied now.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  swmf_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .cfg         (cfg_r),
    .item        (in_data),
    .cur         (core_r),
    .cur_elapsed (elapsed_r),
    .nxt         (core_nxt),
    .nxt_elapsed (elapsed_nxt),
    .result      (step_result)
  );

  // Configuration writes; index seven carries the depth enable in bit zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.limit[swmf_pkg::T_ODOM]   <= 24'd500;
      cfg_r.limit[swmf_pkg::T_LASER]  <= 24'd500;
      cfg_r.limit[swmf_pkg::T_DEPTH]  <= 24'd500;
      cfg_r.limit[swmf_pkg::T_PEOPLE] <= 24'd1200000;
      cfg_r.limit[swmf_pkg::T_FINISH] <= 24'd10000;
      cfg_r.limit[swmf_pkg::T_LOST]   <= 24'd30000;
      cfg_r.limit[swmf_pkg::T_STALL]  <= 24'd40000;
      cfg_r.depth_enabled             <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        swmf_pkg::CFG_ODOM_LIMIT:    cfg_r.limit[swmf_pkg::T_ODOM]   <= cfg_data;
        swmf_pkg::CFG_LASER_LIMIT:   cfg_r.limit[swmf_pkg::T_LASER]  <= cfg_data;
        swmf_pkg::CFG_DEPTH_LIMIT:   cfg_r.limit[swmf_pkg::T_DEPTH]  <= cfg_data;
        swmf_pkg::CFG_PEOPLE_LIMIT:  cfg_r.limit[swmf_pkg::T_PEOPLE] <= cfg_data;
        swmf_pkg::CFG_FINISH_LIMIT:  cfg_r.limit[swmf_pkg::T_FINISH] <= cfg_data;
        swmf_pkg::CFG_LOST_LIMIT:    cfg_r.limit[swmf_pkg::T_LOST]   <= cfg_data;
        swmf_pkg::CFG_STALL_LIMIT:   cfg_r.limit[swmf_pkg::T_STALL]  <= cfg_data;
        swmf_pkg::CFG_DEPTH_ENABLED: cfg_r.depth_enabled             <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // The supervisor state moves only when an item is accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_r.mission     <= swmf_pkg::ST_WAIT_START;
      core_r.target      <= '0;
      core_r.mode        <= '0;
      core_r.finishing   <= 1'b0;
      core_r.last_goal_x <= '0;
      core_r.last_goal_y <= '0;
      elapsed_r          <= '0;
    end else if (in_fire) begin
      core_r    <= core_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  // Result register: filled on accept, emptied when the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= step_result;
    end
  end

  // The reported state is the state the supervisor holds after the item.
  a_result_matches_state : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_data_r.mission_state == core_r.mission))
    else $error("result state differs from the supervisor state");

  // A stop pulse can only come from running or target lost.
  a_stop_from_active : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && step_result.stop_robot) |->
      (core_r.mission == swmf_pkg::ST_RUNNING || core_r.mission == swmf_pkg::ST_LOST))
    else $error("stop pulse outside running or target lost");

  // A rejected command leaves the mission state as it was.
  a_reject_holds_state : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && step_result.cmd_rejected) |=> (core_r.mission == $past(core_r.mission)))
    else $error("rejected command changed the mission state");

  // Entering target lost restarts the lost timer.
  a_lost_timer_cleared : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && core_r.mission != swmf_pkg::ST_LOST &&
     core_nxt.mission == swmf_pkg::ST_LOST) |=> (elapsed_r[swmf_pkg::T_LOST] == '0))
    else $error("lost timer not cleared on entering target lost");

endmodule

// ----- bench/tb_sensor_watchdog_mission_fsm_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sensor_watchdog_mission_fsm_core: testbench for the mission supervisor
// Drives ticks, control cycles, commands and sensor arrivals into the block,
// predicts every result item with an independent model of the supervisor and
// compares each result with the oldest prediction, under random idling on
// both channels, a long result backlog and several register settings.
// ----------------------------------------------------------------------------
module tb_sensor_watchdog_mission_fsm_core;

  // Each side idles in roughly this many cycles out of a hundred.
  localparam int IDLE_PCT    = 24;
  // Cycles without any accepted item before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;
  // Request codes outside the defined set; the block must ignore them.
  localparam logic [3:0] REQ_UNKNOWN_LO = 4'd10;
  localparam logic [3:0] REQ_UNKNOWN_HI = 4'd15;

  logic                                 clk;
  logic                                 rst_n     = 1'b0;
  logic                                 in_valid  = 1'b0;
  logic                                 in_ready;
  swmf_pkg::in_item_t                   in_data   = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  swmf_pkg::out_item_t                  out_data;
  logic                                 cfg_we    = 1'b0;
  logic [swmf_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [swmf_pkg::LIMIT_W-1:0]         cfg_data  = '0;

  sensor_watchdog_mission_fsm_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predicted supervisor state. It starts at the reset values and is advanced
  // once for every item that the block accepts, in acceptance order.
  // --------------------------------------------------------------------------
  logic [3:0]         p_mission  = swmf_pkg::ST_WAIT_START;
  logic [23:0]        p_elapsed [swmf_pkg::N_TIMERS] = '{default: '0};
  logic [15:0]        p_target   = '0;
  logic [7:0]         p_mode     = '0;
  logic               p_fin      = 1'b0;
  logic signed [23:0] p_gx       = '0;
  logic signed [23:0] p_gy       = '0;
  logic               p_stop     = 1'b0;
  // Limits in timer order, and the depth stage enable, as last written.
  logic [23:0]        p_limit [swmf_pkg::N_TIMERS] =
                        '{24'd500, 24'd500, 24'd500, 24'd1200000,
                          24'd10000, 24'd30000, 24'd40000};
  logic               p_depth_en = 1'b1;

  // Results still owed by the block, oldest first.
  swmf_pkg::out_item_t results_due[$];
  int                  faults = 0;

  // Random stimulus state: the finishing flag and the local goal wander slowly
  // so that held flags and unchanged goals actually occur.
  logic               walk_fin = 1'b0;
  logic signed [23:0] walk_gx  = '0;
  logic signed [23:0] walk_gy  = '0;

  // When set, neither side idles.
  bit steady = 1'b0;
  // Cycles for which the receiver refuses results; it counts them down itself.
  int hold_cycles = 0;

  function automatic logic idle_mission(logic [3:0] s);
    return s == swmf_pkg::ST_WAIT_START || s == swmf_pkg::ST_FINISHED ||
           s == swmf_pkg::ST_ABORTED;
  endfunction

  // Moving between the running and lost pair keeps the robot going; any other
  // exit from that pair raises the stop pulse. Re-entering the current state
  // has no effect at all.
  function automatic void enter_state(logic [3:0] s);
    if (s != p_mission) begin
      if ((p_mission == swmf_pkg::ST_RUNNING && s != swmf_pkg::ST_LOST) ||
          (p_mission == swmf_pkg::ST_LOST && s != swmf_pkg::ST_RUNNING))
        p_stop = 1'b1;
      p_mission = s;
      if (s == swmf_pkg::ST_LOST) p_elapsed[swmf_pkg::T_LOST] = '0;
      if (s == swmf_pkg::ST_RUNNING) p_elapsed[swmf_pkg::T_STALL] = '0;
    end
  endfunction

  function automatic swmf_pkg::out_item_t mission_predict(swmf_pkg::in_item_t it);
    swmf_pkg::out_item_t r;
    logic                refused;
    longint              dx;
    longint              dy;
    refused = 1'b0;
    p_stop  = 1'b0;
    case (it.req_type)
      swmf_pkg::REQ_TICK:
        for (int i = 0; i < swmf_pkg::N_TIMERS; i++)
          if (p_elapsed[i] != '1) p_elapsed[i]++;
      swmf_pkg::REQ_CYCLE: begin
        // Sensor watchdog first: the earliest stale sensor in pipeline order
        // wins, and only a later state can fall back to it.
        if (!idle_mission(p_mission)) begin
          if (p_mission != swmf_pkg::ST_WAIT_ODOM &&
              p_elapsed[swmf_pkg::T_ODOM] > p_limit[swmf_pkg::T_ODOM])
            enter_state(swmf_pkg::ST_WAIT_ODOM);
          else if (p_mission > swmf_pkg::ST_WAIT_LASER &&
                   p_elapsed[swmf_pkg::T_LASER] > p_limit[swmf_pkg::T_LASER])
            enter_state(swmf_pkg::ST_WAIT_LASER);
          else if (p_depth_en && p_mission > swmf_pkg::ST_WAIT_DEPTH &&
                   p_elapsed[swmf_pkg::T_DEPTH] > p_limit[swmf_pkg::T_DEPTH])
            enter_state(swmf_pkg::ST_WAIT_DEPTH);
          else if (p_mission > swmf_pkg::ST_WAIT_PEOPLE &&
                   p_elapsed[swmf_pkg::T_PEOPLE] > p_limit[swmf_pkg::T_PEOPLE])
            enter_state(swmf_pkg::ST_WAIT_PEOPLE);
        end
        // Then the ending conditions, while following or searching.
        if (p_mission == swmf_pkg::ST_RUNNING || p_mission == swmf_pkg::ST_LOST) begin
          if (p_mission == swmf_pkg::ST_LOST &&
              p_elapsed[swmf_pkg::T_LOST] > p_limit[swmf_pkg::T_LOST]) begin
            enter_state(swmf_pkg::ST_ABORTED);
          end else begin
            if (!p_fin && it.finishing) p_elapsed[swmf_pkg::T_FINISH] = '0;
            p_fin = it.finishing;
            if (p_mission == swmf_pkg::ST_RUNNING && p_fin &&
                p_elapsed[swmf_pkg::T_FINISH] > p_limit[swmf_pkg::T_FINISH]) begin
              p_fin = 1'b0;
              enter_state(swmf_pkg::ST_FINISHED);
            end else begin
              dx = longint'(p_gx) - longint'($signed(it.goal_x));
              dy = longint'(p_gy) - longint'($signed(it.goal_y));
              if (p_mission == swmf_pkg::ST_RUNNING &&
                  dx * dx + dy * dy < longint'(swmf_pkg::GOAL_EPS_SQ) &&
                  p_elapsed[swmf_pkg::T_STALL] > p_limit[swmf_pkg::T_STALL]) begin
                enter_state(swmf_pkg::ST_ABORTED);
              end else begin
                p_gx = it.goal_x;
                p_gy = it.goal_y;
                p_elapsed[swmf_pkg::T_STALL] = '0;
              end
            end
          end
        end
      end
      swmf_pkg::REQ_START:
        if (!idle_mission(p_mission)) begin
          refused = 1'b1;
        end else begin
          p_target = it.person_id;
          enter_state(swmf_pkg::ST_WAIT_ODOM);
        end
      swmf_pkg::REQ_STOP:
        if (idle_mission(p_mission)) refused = 1'b1;
        else enter_state(swmf_pkg::ST_FINISHED);
      swmf_pkg::REQ_SEL_TARGET:
        if (idle_mission(p_mission)) refused = 1'b1;
        else p_target = it.person_id;
      swmf_pkg::REQ_SEL_MODE:
        if (idle_mission(p_mission)) refused = 1'b1;
        else if (it.mode_code == swmf_pkg::ABORT_MODE) enter_state(swmf_pkg::ST_ABORTED);
        else p_mode = it.mode_code;
      swmf_pkg::REQ_ODOM:
        if (!idle_mission(p_mission) && it.msg_valid) begin
          p_elapsed[swmf_pkg::T_ODOM] = '0;
          if (p_mission == swmf_pkg::ST_WAIT_ODOM) enter_state(swmf_pkg::ST_WAIT_LASER);
        end
      swmf_pkg::REQ_LASER:
        if (!idle_mission(p_mission) && it.msg_valid) begin
          p_elapsed[swmf_pkg::T_LASER] = '0;
          if (p_mission == swmf_pkg::ST_WAIT_LASER)
            enter_state(p_depth_en ? swmf_pkg::ST_WAIT_DEPTH : swmf_pkg::ST_WAIT_PEOPLE);
        end
      swmf_pkg::REQ_DEPTH:
        if (p_depth_en && !idle_mission(p_mission) && it.msg_valid) begin
          p_elapsed[swmf_pkg::T_DEPTH] = '0;
          if (p_mission == swmf_pkg::ST_WAIT_DEPTH) enter_state(swmf_pkg::ST_WAIT_PEOPLE);
        end
      swmf_pkg::REQ_PEOPLE:
        if (!idle_mission(p_mission) && it.msg_valid) begin
          p_elapsed[swmf_pkg::T_PEOPLE] = '0;
          if (p_mission == swmf_pkg::ST_RUNNING && !it.target_found)
            enter_state(swmf_pkg::ST_LOST);
          else if (p_mission == swmf_pkg::ST_LOST && it.target_found)
            enter_state(swmf_pkg::ST_RUNNING);
          else if (p_mission == swmf_pkg::ST_WAIT_PEOPLE)
            enter_state(it.target_found ? swmf_pkg::ST_RUNNING : swmf_pkg::ST_LOST);
        end
      default: ;
    endcase
    r.mission_state  = p_mission;
    r.cmd_rejected   = refused;
    r.stop_robot     = p_stop;
    r.current_target = p_target;
    r.current_mode   = p_mode;
    return r;
  endfunction

  function automatic swmf_pkg::in_item_t make_req(logic [3:0] req, logic [15:0] tid = '0,
                                                  logic [7:0] mode = '0, logic vld = 1'b1,
                                                  logic found = 1'b1, logic fin = 1'b0,
                                                  logic [23:0] gx = '0,
                                                  logic [23:0] gy = '0);
    swmf_pkg::in_item_t it;
    it.req_type     = req;
    it.person_id    = tid;
    it.mode_code    = mode;
    it.msg_valid    = vld;
    it.target_found = found;
    it.finishing    = fin;
    it.goal_x       = gx;
    it.goal_y       = gy;
    return it;
  endfunction

  // Mostly well-formed traffic for the current mission state: from an idle
  // state a start is likely; otherwise ticks, cycles and the awaited sensor
  // dominate, with other sensors, commands and unknown codes mixed in.
  function automatic swmf_pkg::in_item_t pick_request();
    swmf_pkg::in_item_t it;
    int                 roll;
    it.person_id    = 16'($urandom);
    it.mode_code    = 8'($urandom);
    it.msg_valid    = ($urandom_range(9) != 0);
    it.target_found = ($urandom_range(4) != 0);
    if ($urandom_range(19) == 0) walk_fin = !walk_fin;
    it.finishing = walk_fin;
    roll = $urandom_range(9);
    if (roll == 0) begin
      walk_gx = 24'($urandom);
      walk_gy = 24'($urandom);
    end else if (roll < 4) begin
      walk_gx += 24'($urandom_range(16)) - 24'd8;
      walk_gy += 24'($urandom_range(16)) - 24'd8;
    end
    it.goal_x = walk_gx;
    it.goal_y = walk_gy;

    roll = $urandom_range(99);
    if (idle_mission(p_mission)) begin
      it.req_type = (roll < 60) ? swmf_pkg::REQ_START : 4'($urandom_range(15));
    end else if (roll < 30) begin
      it.req_type = swmf_pkg::REQ_TICK;
    end else if (roll < 48) begin
      it.req_type = swmf_pkg::REQ_CYCLE;
    end else if (roll < 68) begin
      case (p_mission)
        swmf_pkg::ST_WAIT_ODOM:   it.req_type = swmf_pkg::REQ_ODOM;
        swmf_pkg::ST_WAIT_LASER:  it.req_type = swmf_pkg::REQ_LASER;
        swmf_pkg::ST_WAIT_DEPTH:  it.req_type = swmf_pkg::REQ_DEPTH;
        swmf_pkg::ST_WAIT_PEOPLE: it.req_type = swmf_pkg::REQ_PEOPLE;
        default:                  it.req_type = swmf_pkg::REQ_ODOM + 4'($urandom_range(3));
      endcase
    end else if (roll < 85) begin
      it.req_type = swmf_pkg::REQ_ODOM + 4'($urandom_range(3));
    end else if (roll < 90) begin
      it.req_type = swmf_pkg::REQ_SEL_TARGET;
    end else if (roll < 94) begin
      it.req_type = swmf_pkg::REQ_SEL_MODE;
      if ($urandom_range(5) == 0) it.mode_code = swmf_pkg::ABORT_MODE;
    end else if (roll < 96) begin
      it.req_type = swmf_pkg::REQ_STOP;
    end else if (roll < 98) begin
      it.req_type = swmf_pkg::REQ_START;
    end else begin
      it.req_type = 4'($urandom_range(15));
    end
    return it;
  endfunction

  // Offers one item and returns at the edge where it is taken. Valid is left
  // high so that the next item can follow without a gap.
  task automatic send_item(input swmf_pkg::in_item_t it);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    results_due.insert(results_due.size(), mission_predict(it));
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) send_item(pick_request());
  endtask

  // Stops offering items and waits until every owed result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Holds the write enable high across consecutive register writes; the
  // caller lowers it after the last one.
  task automatic put_reg(input logic [swmf_pkg::CFG_IDX_W-1:0] idx,
                         input logic [swmf_pkg::LIMIT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic write_settings(input logic [23:0] lims [swmf_pkg::N_TIMERS],
                                input logic den);
    drain_results();
    put_reg(swmf_pkg::CFG_ODOM_LIMIT,    lims[swmf_pkg::T_ODOM]);
    put_reg(swmf_pkg::CFG_LASER_LIMIT,   lims[swmf_pkg::T_LASER]);
    put_reg(swmf_pkg::CFG_DEPTH_LIMIT,   lims[swmf_pkg::T_DEPTH]);
    put_reg(swmf_pkg::CFG_PEOPLE_LIMIT,  lims[swmf_pkg::T_PEOPLE]);
    put_reg(swmf_pkg::CFG_FINISH_LIMIT,  lims[swmf_pkg::T_FINISH]);
    put_reg(swmf_pkg::CFG_LOST_LIMIT,    lims[swmf_pkg::T_LOST]);
    put_reg(swmf_pkg::CFG_STALL_LIMIT,   lims[swmf_pkg::T_STALL]);
    put_reg(swmf_pkg::CFG_DEPTH_ENABLED, swmf_pkg::LIMIT_W'(den));
    cfg_we <= 1'b0;
    p_limit    = lims;
    p_depth_en = den;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Commands rejected in the wrong states, sensors ignored while idle or when
  // not accepted, the full start-up chain, the running and lost pair, stop,
  // the abort mode, unknown codes and the extremes of every field.
  task automatic test_command_rules();
    send_item(make_req(swmf_pkg::REQ_CYCLE));
    send_item(make_req(swmf_pkg::REQ_STOP));
    send_item(make_req(swmf_pkg::REQ_SEL_TARGET, 16'hFFFF));
    send_item(make_req(swmf_pkg::REQ_SEL_MODE, '0, 8'h07));
    send_item(make_req(swmf_pkg::REQ_ODOM));
    send_item(make_req(REQ_UNKNOWN_HI, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b1, '1, '1));
    send_item(make_req(swmf_pkg::REQ_START, 16'hFFFF));
    send_item(make_req(swmf_pkg::REQ_START, 16'h0001));
    send_item(make_req(swmf_pkg::REQ_ODOM, '0, '0, 1'b0));
    send_item(make_req(swmf_pkg::REQ_ODOM));
    send_item(make_req(swmf_pkg::REQ_LASER));
    send_item(make_req(swmf_pkg::REQ_DEPTH));
    send_item(make_req(swmf_pkg::REQ_PEOPLE, '0, '0, 1'b1, 1'b0));
    send_item(make_req(swmf_pkg::REQ_PEOPLE));
    send_item(make_req(swmf_pkg::REQ_SEL_TARGET, 16'h0000));
    send_item(make_req(swmf_pkg::REQ_SEL_MODE, '0, 8'hFF));
    send_item(make_req(swmf_pkg::REQ_CYCLE, '0, '0, 1'b1, 1'b1, 1'b1,
                       24'h7FFFFF, 24'h800000));
    send_item(make_req(swmf_pkg::REQ_CYCLE, '0, '0, 1'b1, 1'b1, 1'b0,
                       24'h800000, 24'h7FFFFF));
    send_item(make_req(swmf_pkg::REQ_PEOPLE, '0, '0, 1'b1, 1'b0));
    // Stopping from the lost state must raise the stop pulse.
    send_item(make_req(swmf_pkg::REQ_STOP));
    send_item(make_req(swmf_pkg::REQ_SEL_MODE, '0, 8'h33));
    send_item(make_req(swmf_pkg::REQ_START, 16'hA5A5));
    send_item(make_req(swmf_pkg::REQ_SEL_MODE, '0, swmf_pkg::ABORT_MODE));
    send_item(make_req(REQ_UNKNOWN_LO));
  endtask

  // With the depth stage switched off while the supervisor waits for it, the
  // supervisor must stay put until the stage is switched back on.
  task automatic test_depth_bypass();
    send_item(make_req(swmf_pkg::REQ_START, 16'h1234));
    send_item(make_req(swmf_pkg::REQ_ODOM));
    send_item(make_req(swmf_pkg::REQ_LASER));
    write_settings(p_limit, 1'b0);
    send_item(make_req(swmf_pkg::REQ_DEPTH));
    send_item(make_req(swmf_pkg::REQ_CYCLE));
    send_item(make_req(swmf_pkg::REQ_PEOPLE));
    write_settings(p_limit, 1'b1);
    send_item(make_req(swmf_pkg::REQ_DEPTH));
    send_item(make_req(swmf_pkg::REQ_PEOPLE));
  endtask

  // Random missions under several settings: all limits zero, all limits at
  // their maximum with the depth stage off, then small random limits that let
  // every watchdog, the stall and lost aborts and finishing fire often.
  task automatic test_random_missions();
    logic [23:0] lims [swmf_pkg::N_TIMERS];
    logic        den;
    for (int ph = 0; ph < 9; ph++) begin
      for (int i = 0; i < swmf_pkg::N_TIMERS; i++)
        if (ph == 0) lims[i] = '0;
        else if (ph == 1) lims[i] = '1;
        else lims[i] = ($urandom_range(7) == 0) ? '1 : 24'($urandom_range(12));
      den = (ph == 1) ? 1'b0 : 1'($urandom_range(3) != 0);
      write_settings(lims, den);
      // One phase runs flat out with no idling on either side.
      steady = (ph == 2);
      send_random(100);
    end
    steady = 1'b0;
  endtask

  // The receiver refuses results for a long stretch while items keep coming,
  // so the output register fills and the input must stall.
  task automatic test_result_backlog();
    hold_cycles = 120;
    send_random(20);
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Result side: random readiness, with the backlog hold counted down here.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic void log_fault(string msg);
    faults++;
    if (faults <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Every result taken is checked against the oldest prediction.
  always @(posedge clk) begin
    swmf_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        log_fault($sformatf("unexpected result: state %0d err %0b stop %0b target %h mode %h",
                            out_data.mission_state, out_data.cmd_rejected,
                            out_data.stop_robot, out_data.current_target,
                            out_data.current_mode));
      end else begin
        want = results_due.pop_front();
        if (out_data.mission_state !== want.mission_state ||
            out_data.cmd_rejected !== want.cmd_rejected ||
            out_data.stop_robot !== want.stop_robot ||
            out_data.current_target !== want.current_target ||
            out_data.current_mode !== want.current_mode)
          log_fault($sformatf({"result mismatch: expected state %0d err %0b stop %0b ",
                               "target %h mode %h, got state %0d err %0b stop %0b ",
                               "target %h mode %h"},
                              want.mission_state, want.cmd_rejected, want.stop_robot,
                              want.current_target, want.current_mode,
                              out_data.mission_state, out_data.cmd_rejected,
                              out_data.stop_robot, out_data.current_target,
                              out_data.current_mode));
      end
    end
  end

  // Ends a hung run: too many cycles in a row with nothing taken on either side.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_command_rules();
    test_depth_bypass();
    test_random_missions();
    test_result_backlog();

    drain_results();
    repeat (4) @(posedge clk);
    if (faults == 0 && results_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/swmf_pkg.sv
src/swmf_step.sv
src/sensor_watchdog_mission_fsm_core.sv
bench/tb_sensor_watchdog_mission_fsm_core.sv
